// ===== rtl/hpec_pkg.sv =====
`timescale 1ns / 1ps

package hpec_pkg;

  localparam int COUNTER_BITS = 32;
  localparam int NUM_TOTALS   = 8;
  localparam int FLAG_BITS    = 9;
  localparam int OUT_BITS     = 32 + FLAG_BITS + NUM_TOTALS * 32;
  localparam int OUT_BYTES    = (OUT_BITS + 7) / 8;

  localparam logic [7:0] GAP_CHAR = 8'h2D;

  localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

  // event flag bits, also the total index for bits below TRUE_INDEL
  localparam int EV_SW_A      = 0;
  localparam int EV_SW_B      = 1;
  localparam int EV_SNP_A     = 2;
  localparam int EV_SNP_B     = 3;
  localparam int EV_IND_A     = 4;
  localparam int EV_IND_B     = 5;
  localparam int EV_BAD_A     = 6;
  localparam int EV_BAD_B     = 7;
  localparam int EV_TRUE_INDEL = 8;

  typedef enum logic [1:0] {
    PH_UNKNOWN = 2'd0,
    PH_ONE     = 2'd1,
    PH_TWO     = 2'd2
  } phase_t;

  typedef struct packed {
    logic [FLAG_BITS-1:0] flags;
    phase_t               phase_a;
    phase_t               phase_b;
  } hpec_class_t;

  function automatic logic [31:0] sat32(input logic [COUNTER_BITS-1:0] v);
    logic [63:0] ext;
    ext = 64'(v);
    return (ext > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : ext[31:0];
  endfunction

endpackage

// ===== rtl/hpec_classify.sv =====
`timescale 1ns / 1ps

module hpec_classify
  import hpec_pkg::*;
(
  input  logic [7:0]  true_base_a,
  input  logic [7:0]  true_base_b,
  input  logic [7:0]  test_base_a,
  input  logic [7:0]  test_base_b,
  input  phase_t      phase_a,
  input  phase_t      phase_b,
  output hpec_class_t cls
);

  logic gap_ea;
  logic gap_eb;
  logic homo;
  logic het;
  logic ea_t1, ea_t2, eb_t1, eb_t2;

  always_comb begin
    gap_ea = (test_base_a == GAP_CHAR);
    gap_eb = (test_base_b == GAP_CHAR);
    homo   = (true_base_a == true_base_b);
    het    = !homo && (true_base_a != GAP_CHAR) && (true_base_b != GAP_CHAR);
    ea_t1  = (test_base_a == true_base_a);
    ea_t2  = (test_base_a == true_base_b);
    eb_t1  = (test_base_b == true_base_a);
    eb_t2  = (test_base_b == true_base_b);

    cls.flags   = '0;
    cls.phase_a = phase_a;
    cls.phase_b = phase_b;

    if (homo) begin
      if (gap_ea || gap_eb) begin
        cls.flags[EV_IND_A] = !gap_ea;
        cls.flags[EV_IND_B] = !gap_eb;
      end else if (test_base_a != test_base_b) begin
        if (!ea_t1) begin
          cls.flags[EV_SNP_A] = 1'b1;
        end else begin
          cls.flags[EV_SNP_B] = 1'b1;
        end
      end
    end else if (het) begin
      if (ea_t1) begin
        cls.flags[EV_SW_A] = (phase_a == PH_TWO);
        cls.phase_a        = PH_ONE;
      end else if (ea_t2) begin
        cls.flags[EV_SW_A] = (phase_a == PH_ONE);
        cls.phase_a        = PH_TWO;
      end else begin
        cls.flags[EV_BAD_A] = 1'b1;
      end
      if (eb_t1) begin
        cls.flags[EV_SW_B] = (phase_b == PH_TWO);
        cls.phase_b        = PH_ONE;
      end else if (eb_t2) begin
        cls.flags[EV_SW_B] = (phase_b == PH_ONE);
        cls.phase_b        = PH_TWO;
      end else begin
        cls.flags[EV_BAD_B] = 1'b1;
      end
    end else begin
      cls.flags[EV_TRUE_INDEL] = 1'b1;
      if (!ea_t1 && !ea_t2) begin
        cls.flags[EV_SNP_A] = 1'b1;
      end else if (!eb_t1 && !eb_t2) begin
        cls.flags[EV_SNP_B] = 1'b1;
      end
    end
  end

endmodule

// ===== rtl/haplotype_phase_error_counter.sv =====
`timescale 1ns / 1ps

// Haplotype phase error counter. Each input item is one alignment column (two true and
// two test haplotype bases, ASCII, '-' for a gap); each column yields exactly one result
// item carrying its one-based position, its event flags and the eight running error totals
// including that column. One column is accepted per clock cycle while the output is not
// stalled; a column waits in the input register until the result register can take it;
// its result is then loaded there and out_tvalid rises. The phase and counter state
// update in that same cycle so consecutive columns never wait on each other; a stalled
// output holds at most two columns before in_tready drops. Totals saturate at all ones;
// a column with tlast set returns its result and then clears the phases, position and
// totals for the next run.
module haplotype_phase_error_counter
  import hpec_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // true_base_a[7:0], true_base_b[15:8], test_base_a[23:16], test_base_b[31:24]
  input  logic [31:0]            in_tdata,
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // position[31:0], event_flags[40:32], switches_a[72:41], switches_b[104:73],
  // false_snps_a[136:105], false_snps_b[168:137], false_indels_a[200:169],
  // false_indels_b[232:201], bad_calls_a[264:233], bad_calls_b[296:265], zero[303:297]
  output logic [OUT_BYTES*8-1:0] out_tdata
);

  logic                    s1_valid_r;
  logic [31:0]             s1_data_r;
  logic                    s1_last_r;
  logic                    out_valid_r;
  logic [OUT_BYTES*8-1:0]  out_data_r;
  logic [OUT_BYTES*8-1:0]  out_data_nxt;

  phase_t                  phase_a_r;
  phase_t                  phase_b_r;
  logic [31:0]             col_r;
  logic [31:0]             col_nxt;
  logic [COUNTER_BITS-1:0] tot_r   [NUM_TOTALS];
  logic [COUNTER_BITS-1:0] tot_nxt [NUM_TOTALS];

  logic                    advance;
  hpec_class_t             cls;

  assign advance    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  hpec_classify u_classify (
    .true_base_a (s1_data_r[7:0]),
    .true_base_b (s1_data_r[15:8]),
    .test_base_a (s1_data_r[23:16]),
    .test_base_b (s1_data_r[31:24]),
    .phase_a     (phase_a_r),
    .phase_b     (phase_b_r),
    .cls         (cls)
  );

  always_comb begin
    col_nxt = (col_r == 32'hFFFF_FFFF) ? col_r : col_r + 32'd1;
    for (int k = 0; k < NUM_TOTALS; k++) begin
      tot_nxt[k] = (cls.flags[k] && (tot_r[k] != CNT_MAX)) ?
                   tot_r[k] + COUNTER_BITS'(1) : tot_r[k];
    end
    out_data_nxt = '0;
    out_data_nxt[31:0]  = col_nxt;
    out_data_nxt[40:32] = cls.flags;
    for (int k = 0; k < NUM_TOTALS; k++) begin
      out_data_nxt[32 + FLAG_BITS + k*32 +: 32] = sat32(tot_nxt[k]);
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_data_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  // column state; clear after the last column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_a_r <= PH_UNKNOWN;
      phase_b_r <= PH_UNKNOWN;
      col_r     <= '0;
      for (int k = 0; k < NUM_TOTALS; k++) begin
        tot_r[k] <= '0;
      end
    end else if (advance) begin
      if (s1_last_r) begin
        phase_a_r <= PH_UNKNOWN;
        phase_b_r <= PH_UNKNOWN;
        col_r     <= '0;
        for (int k = 0; k < NUM_TOTALS; k++) begin
          tot_r[k] <= '0;
        end
      end else begin
        phase_a_r <= cls.phase_a;
        phase_b_r <= cls.phase_b;
        col_r     <= col_nxt;
        for (int k = 0; k < NUM_TOTALS; k++) begin
          tot_r[k] <= tot_nxt[k];
        end
      end
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_last_r |=> col_r == 32'd0 && phase_a_r == PH_UNKNOWN)
    else $error("state not cleared after last column");

  a_col_steps: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !s1_last_r && col_r != 32'hFFFF_FFFF |=> col_r == $past(col_r) + 32'd1)
    else $error("column position did not advance");

  a_sw_bad_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r[32 + EV_SW_A] && out_data_r[32 + EV_BAD_A]) &&
                    !(out_data_r[32 + EV_SW_B] && out_data_r[32 + EV_BAD_B]))
    else $error("switch and bad call flagged together");

  a_indel_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[32 + EV_TRUE_INDEL] |->
      out_data_r[33:32] == 2'b00 && out_data_r[39:36] == 4'b0000 &&
      !(out_data_r[32 + EV_SNP_A] && out_data_r[32 + EV_SNP_B]))
    else $error("bad flag set on true indel column");

  a_no_phase_three: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> $past(cls.flags[EV_BAD_A]) |-> phase_a_r == $past(phase_a_r) ||
                $past(s1_last_r))
    else $error("bad call changed phase");

endmodule
